FILE: design/rcpa_pkg.sv
// rcpa_pkg: shared types and constants of the refcounted page allocator
// opcodes, status codes, register indexes and reset values; no dependencies
`timescale 1ns / 1ps

package rcpa_pkg;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_SHARE  = 2'd2,
      OP_DONATE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ADDR  = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_UNOWNED   = 3'd3,
      ST_SATURATED = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_FIRST_ADDR = 1'b0,
      CSR_LIMIT_ADDR = 1'b1
   } csr_type;

   localparam logic [31:0] FIRST_ADDR_RESET = 32'h8000_0000;
   localparam logic [31:0] LIMIT_ADDR_RESET = 32'h8800_0000;

   // classified request handed from front to back
   typedef struct packed {
      op_type op;
      logic   bad;
   } cmd_type;

endpackage

FILE: design/refcounted_page_allocator_unit.sv
// refcounted_page_allocator_unit: a request is queued in the front, popped in the back
// end's issue state and executed in its execute state, which registers the result; the
// back end finishes one request before popping the next, due to the read-then-write of
// the share-count and free-stack memories; after reset a clearing pass zeroes the share
// counts of all pages while req_ready stays low; config writes are taken throughout
// depends on rcpa_pkg, rcpa_front, rcpa_back, rcpa_ram
`timescale 1ns / 1ps

module refcounted_page_allocator_unit #(
   parameter int PAGES      = 32768,
   parameter int PAGE_BITS  = 12,
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_page_address,
   output logic [7:0]  rsp_share_count,
   output logic        rsp_released,
   output logic [15:0] rsp_free_pages
);

   localparam int IDX_W = $clog2(PAGES);

   logic              accept_en;
   logic              cmd_valid;
   rcpa_pkg::cmd_type cmd;
   logic [IDX_W-1:0]  cmd_idx;
   logic              cmd_pop;
   logic [31:0]       base_addr;

   rcpa_front #(.PAGES(PAGES), .PAGE_BITS(PAGE_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_op      (req_op),
      .req_address (req_address),
      .accept_en   (accept_en),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .cmd_pop     (cmd_pop),
      .base_addr   (base_addr)
   );

   rcpa_back #(.PAGES(PAGES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_idx          (cmd_idx),
      .cmd_pop          (cmd_pop),
      .base_addr        (base_addr),
      .accept_en        (accept_en),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_page_address (rsp_page_address),
      .rsp_share_count  (rsp_share_count),
      .rsp_released     (rsp_released),
      .rsp_free_pages   (rsp_free_pages)
   );

endmodule

FILE: design/rcpa_ram.sv
// rcpa_ram: generic single-write, single-read memory with registered read data
// depends on nothing; read returns the old word on a same-address write
`timescale 1ns / 1ps

module rcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/rcpa_front.sv
// rcpa_front: config registers, request address check and two-entry command queue
// depends on rcpa_pkg
`timescale 1ns / 1ps

module rcpa_front #(
   parameter int PAGES     = 32768,
   parameter int PAGE_BITS = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [31:0]                csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_op,
   input  logic [31:0]                req_address,
   input  logic                       accept_en,
   output logic                       cmd_valid,
   output rcpa_pkg::cmd_type          cmd,
   output logic [$clog2(PAGES)-1:0]   cmd_idx,
   input  logic                       cmd_pop,
   output logic [31:0]                base_addr
);

   localparam int IDX_W = $clog2(PAGES);
   localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_BITS) - 33'd1;
   localparam logic [32:0] BASE_RESET =
      (33'(rcpa_pkg::FIRST_ADDR_RESET) + PAGE_MASK) & ~PAGE_MASK;
   localparam logic [32:0] PAGES_LIMIT = 33'(PAGES);

   logic [31:0] first_ff, first_in;
   logic [31:0] limit_ff, limit_in;
   logic [32:0] base_ff, base_in;

   rcpa_pkg::cmd_type q_cmd_ff [2];
   logic [IDX_W-1:0]  q_idx_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   logic [32:0]       csr_base;
   logic [32:0]       addr_ext;
   logic [32:0]       offset;
   logic              bad;
   logic              push;
   rcpa_pkg::cmd_type new_cmd;

   // config writes
   always_comb begin
      first_in = first_ff;
      limit_in = limit_ff;
      base_in  = base_ff;
      csr_base = ({1'b0, csr_wdata} + PAGE_MASK) & ~PAGE_MASK;
      if (csr_we) begin
         unique case (csr_index)
            rcpa_pkg::CSR_FIRST_ADDR: begin
               first_in = csr_wdata;
               base_in  = csr_base;
            end
            rcpa_pkg::CSR_LIMIT_ADDR: begin
               limit_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // address classification
   always_comb begin
      addr_ext = {1'b0, req_address};
      offset   = (addr_ext - base_ff) >> PAGE_BITS;
      bad      = ((addr_ext & PAGE_MASK) != 33'd0) || (req_address < first_ff) ||
                 (req_address >= limit_ff) || (addr_ext < base_ff) ||
                 (offset >= PAGES_LIMIT);
      new_cmd.op  = rcpa_pkg::op_type'(req_op);
      new_cmd.bad = bad;
   end

   assign req_ready = accept_en && (count_ff != 2'd2);
   assign push      = req_valid && req_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= rcpa_pkg::FIRST_ADDR_RESET;
         limit_ff  <= rcpa_pkg::LIMIT_ADDR_RESET;
         base_ff   <= BASE_RESET;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         first_ff  <= first_in;
         limit_ff  <= limit_in;
         base_ff   <= base_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_cmd_ff[wr_ptr_ff] <= new_cmd;
         q_idx_ff[wr_ptr_ff] <= offset[IDX_W-1:0];
      end
   end

   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_cmd_ff[rd_ptr_ff];
   assign cmd_idx   = q_idx_ff[rd_ptr_ff];
   assign base_addr = base_ff[31:0];

endmodule

FILE: design/rcpa_back.sv
// rcpa_back: executes queued commands against the share-count and free-stack memories
// depends on rcpa_pkg and rcpa_ram; runs the share-count clearing pass after reset
`timescale 1ns / 1ps

module rcpa_back #(
   parameter int PAGES      = 32768,
   parameter int PAGE_BITS  = 12,
   parameter int COUNT_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  rcpa_pkg::cmd_type        cmd,
   input  logic [$clog2(PAGES)-1:0] cmd_idx,
   output logic                     cmd_pop,
   input  logic [31:0]              base_addr,
   output logic                     accept_en,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [2:0]               rsp_status,
   output logic [31:0]              rsp_page_address,
   output logic [7:0]               rsp_share_count,
   output logic                     rsp_released,
   output logic [15:0]              rsp_free_pages
);

   localparam int IDX_W   = $clog2(PAGES);
   localparam int DEPTH_W = $clog2(PAGES + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [DEPTH_W-1:0]    DEPTH_FULL = DEPTH_W'(PAGES);
   localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(PAGES - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_ISSUE,
      S_EXEC
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       clr_cnt_ff, clr_cnt_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   rcpa_pkg::cmd_type      cur_cmd_ff, cur_cmd_in;
   logic [IDX_W-1:0]       cur_idx_ff, cur_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rcpa_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_page_ff, rsp_page_in;
   logic [7:0]             rsp_count_ff, rsp_count_in;
   logic                   rsp_released_ff, rsp_released_in;
   logic [15:0]            rsp_free_ff, rsp_free_in;

   logic                   share_we;
   logic [IDX_W-1:0]       share_waddr;
   logic [COUNT_BITS-1:0]  share_wdata;
   logic [COUNT_BITS-1:0]  share_rdata;
   logic                   stack_we;
   logic [IDX_W-1:0]       stack_waddr;
   logic [IDX_W-1:0]       stack_wdata;
   logic [IDX_W-1:0]       stack_raddr;
   logic [IDX_W-1:0]       stack_rdata;

   logic [DEPTH_W-1:0]     depth_m1;
   logic [COUNT_BITS-1:0]  cnt;
   logic [COUNT_BITS-1:0]  held;
   logic [15:0]            cnt_ext;
   logic [31:0]            depth_ext;

   rcpa_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAGES)) u_share_ram (
      .clock   (clock),
      .wr_en   (share_we),
      .wr_addr (share_waddr),
      .wr_data (share_wdata),
      .rd_addr (cmd_idx),
      .rd_data (share_rdata)
   );

   rcpa_ram #(.WIDTH(IDX_W), .DEPTH(PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (stack_wdata),
      .rd_addr (stack_raddr),
      .rd_data (stack_rdata)
   );

   assign depth_m1    = depth_ff - DEPTH_W'(1);
   assign stack_raddr = depth_m1[IDX_W-1:0];
   assign accept_en   = (state_ff != S_CLEAR);
   assign cmd_pop     = (state_ff == S_ISSUE) && cmd_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in        = state_ff;
      clr_cnt_in      = clr_cnt_ff;
      depth_in        = depth_ff;
      cur_cmd_in      = cur_cmd_ff;
      cur_idx_in      = cur_idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_page_in     = rsp_page_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_released_in = rsp_released_ff;
      rsp_free_in     = rsp_free_ff;
      share_we        = 1'b0;
      share_waddr     = cur_idx_ff;
      share_wdata     = '0;
      stack_we        = 1'b0;
      stack_waddr     = depth_ff[IDX_W-1:0];
      stack_wdata     = cur_idx_ff;
      cnt             = '0;
      held            = '0;
      cnt_ext         = '0;
      depth_ext       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            share_we    = 1'b1;
            share_waddr = clr_cnt_ff;
            clr_cnt_in  = clr_cnt_ff + IDX_W'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (cmd_pop) begin
               cur_cmd_in = cmd;
               cur_idx_in = cmd_idx;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_status_in   = rcpa_pkg::ST_OK;
            rsp_page_in     = 32'd0;
            rsp_released_in = 1'b0;
            if (cur_cmd_ff.op == rcpa_pkg::OP_ALLOC) begin
               if (depth_ff == '0) begin
                  rsp_status_in = rcpa_pkg::ST_EMPTY;
               end else begin
                  depth_in    = depth_m1;
                  share_we    = 1'b1;
                  share_waddr = stack_rdata;
                  share_wdata = COUNT_ONE;
                  cnt         = COUNT_ONE;
                  rsp_page_in = base_addr + (32'(stack_rdata) << PAGE_BITS);
               end
            end else if (cur_cmd_ff.bad) begin
               rsp_status_in = rcpa_pkg::ST_BAD_ADDR;
            end else if (cur_cmd_ff.op == rcpa_pkg::OP_SHARE) begin
               cnt = share_rdata;
               if (share_rdata == COUNT_MAX) begin
                  rsp_status_in = rcpa_pkg::ST_SATURATED;
               end else begin
                  cnt         = share_rdata + COUNT_ONE;
                  share_we    = 1'b1;
                  share_wdata = cnt;
               end
            end else begin
               held = (cur_cmd_ff.op == rcpa_pkg::OP_DONATE) ? COUNT_ONE : share_rdata;
               if (held == '0) begin
                  rsp_status_in = rcpa_pkg::ST_UNOWNED;
               end else begin
                  cnt         = held - COUNT_ONE;
                  share_we    = 1'b1;
                  share_wdata = cnt;
                  if (cnt == '0) begin
                     if (depth_ff >= DEPTH_FULL) begin
                        rsp_status_in = rcpa_pkg::ST_UNOWNED;
                     end else begin
                        stack_we        = 1'b1;
                        depth_in        = depth_ff + DEPTH_W'(1);
                        rsp_released_in = 1'b1;
                     end
                  end
               end
            end
            cnt_ext      = 16'(cnt);
            depth_ext    = 32'(depth_in);
            rsp_count_in = cnt_ext[7:0];
            rsp_free_in  = depth_ext[15:0];
            rsp_valid_in = 1'b1;
            state_in     = S_ISSUE;
         end
         default: begin
            state_in = S_ISSUE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_cnt_ff      <= '0;
         depth_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clr_cnt_ff      <= clr_cnt_in;
         depth_ff        <= depth_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cur_cmd_ff      <= cur_cmd_in;
      cur_idx_ff      <= cur_idx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_page_ff     <= rsp_page_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_released_ff <= rsp_released_in;
      rsp_free_ff     <= rsp_free_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_page_address = rsp_page_ff;
   assign rsp_share_count  = rsp_count_ff;
   assign rsp_released     = rsp_released_ff;
   assign rsp_free_pages   = rsp_free_ff;

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from an empty queue");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_FULL)
      else $error("free stack depth above page count");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> !rsp_valid_ff)
      else $error("result register still occupied when executing");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised outside execute");

   a_released_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_released_ff) |-> (rsp_status_ff == rcpa_pkg::ST_OK))
      else $error("page released with failing status");

endmodule

FILE: verif/refcounted_page_allocator_checker.sv
// refcounted_page_allocator_checker: watches the request, reply and register ports,
// predicts every reply from its own copy of the pool state and compares field by field
// depends on rcpa_pkg
`timescale 1ns / 1ps

module refcounted_page_allocator_checker #(
   parameter int PAGES      = 32768,
   parameter int PAGE_BITS  = 12,
   parameter int COUNT_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_address,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_page_address,
   input  logic [7:0]  rsp_share_count,
   input  logic        rsp_released,
   input  logic [15:0] rsp_free_pages,
   output int          mismatches,
   output int          replies_owed
);

   localparam int IDX_BITS = $clog2(PAGES);
   localparam logic [32:0] PAGE_MASK = (33'd1 << PAGE_BITS) - 33'd1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      rcpa_pkg::status_type status;
      logic [31:0]          page_address;
      logic [7:0]           share_count;
      logic                 released;
      logic [15:0]          free_pages;
   } reply_type;

   logic [31:0]           first_addr;
   logic [31:0]           limit_addr;
   logic [IDX_BITS-1:0]   free_stack [PAGES];
   logic [IDX_BITS:0]     stack_depth;
   logic [COUNT_BITS-1:0] share_table [PAGES];
   reply_type             predicted_replies [$];

   function automatic logic [32:0] rounded_base();
      return ({1'b0, first_addr} + PAGE_MASK) & ~PAGE_MASK;
   endfunction

   function automatic logic lookup_page(logic [31:0] addr, output logic [IDX_BITS-1:0] idx);
      logic [32:0] base;
      logic [32:0] offset;
      base = rounded_base();
      idx = '0;
      if (({1'b0, addr} & PAGE_MASK) != 33'd0) return 1'b0;
      if (addr < first_addr || addr >= limit_addr) return 1'b0;
      if ({1'b0, addr} < base) return 1'b0;
      offset = ({1'b0, addr} - base) >> PAGE_BITS;
      if (offset >= PAGES) return 1'b0;
      idx = offset[IDX_BITS-1:0];
      return 1'b1;
   endfunction

   function automatic reply_type apply_page_op(rcpa_pkg::op_type op, logic [31:0] addr);
      reply_type             r;
      logic [IDX_BITS-1:0]   idx;
      logic [COUNT_BITS-1:0] cnt;
      r = '0;
      r.status = rcpa_pkg::ST_OK;
      if (op == rcpa_pkg::OP_ALLOC) begin
         if (stack_depth == 0) begin
            r.status = rcpa_pkg::ST_EMPTY;
         end else begin
            stack_depth = stack_depth - 1'b1;
            idx = free_stack[stack_depth];
            share_table[idx] = 1;
            r.share_count = 8'd1;
            r.page_address = 32'(rounded_base() + (33'(idx) << PAGE_BITS));
         end
      end else if (!lookup_page(addr, idx)) begin
         r.status = rcpa_pkg::ST_BAD_ADDR;
      end else if (op == rcpa_pkg::OP_SHARE) begin
         cnt = share_table[idx];
         if (cnt == COUNT_MAX) begin
            r.status = rcpa_pkg::ST_SATURATED;
         end else begin
            cnt = cnt + 1'b1;
            share_table[idx] = cnt;
         end
         r.share_count = 8'(cnt);
      end else begin
         if (op == rcpa_pkg::OP_DONATE) share_table[idx] = 1;
         cnt = share_table[idx];
         if (cnt == 0) begin
            r.status = rcpa_pkg::ST_UNOWNED;
         end else begin
            cnt = cnt - 1'b1;
            share_table[idx] = cnt;
            if (cnt == 0) begin
               // a full stack drops the push
               if (stack_depth >= PAGES) begin
                  r.status = rcpa_pkg::ST_UNOWNED;
               end else begin
                  free_stack[stack_depth] = idx;
                  stack_depth = stack_depth + 1'b1;
                  r.released = 1'b1;
               end
            end
         end
         r.share_count = 8'(cnt);
      end
      r.free_pages = 16'(stack_depth);
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         first_addr = rcpa_pkg::FIRST_ADDR_RESET;
         limit_addr = rcpa_pkg::LIMIT_ADDR_RESET;
         for (int i = 0; i < PAGES; i++) share_table[i] = '0;
         stack_depth = '0;
         mismatches = 0;
         predicted_replies.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == rcpa_pkg::CSR_FIRST_ADDR) first_addr = csr_wdata;
            else limit_addr = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (predicted_replies.size() == 0) begin
               $error("reply with no request outstanding");
               mismatches++;
            end else begin
               want = predicted_replies.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("page_address", want.page_address, rsp_page_address);
               compare_field("share_count", 32'(want.share_count), 32'(rsp_share_count));
               compare_field("released", 32'(want.released), 32'(rsp_released));
               compare_field("free_pages", 32'(want.free_pages), 32'(rsp_free_pages));
            end
         end
         if (req_valid && req_ready)
            predicted_replies.push_back(
               apply_page_op(rcpa_pkg::op_type'(req_op), req_address));
      end
      replies_owed <= predicted_replies.size();
   end

endmodule

FILE: verif/tb_refcounted_page_allocator_unit.sv
// tb_refcounted_page_allocator_unit: drives directed and random page requests through
// several address windows and a run of donated pages; the checker judges every reply
// depends on rcpa_pkg, refcounted_page_allocator_unit, refcounted_page_allocator_checker
`timescale 1ns / 1ps

module tb_refcounted_page_allocator_unit;

   localparam int PAGES = 32768;
   localparam int PAGE_BITS = 12;
   localparam int COUNT_BITS = 8;
   localparam logic [31:0] PAGE_BYTES = 32'd1 << PAGE_BITS;
   localparam int WATCHDOG_LIMIT = 140000;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_page_address;
   logic [7:0]  rsp_share_count;
   logic        rsp_released;
   logic [15:0] rsp_free_pages;

   int          mismatches;
   int          replies_owed;
   int          quiet_cycles = 0;
   logic        stalls_on = 1'b1;
   logic [31:0] window_base;
   logic [31:0] window_limit;

   always #5 clock = ~clock;

   refcounted_page_allocator_unit #(
      .PAGES(PAGES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
   ) u_dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_page_address(rsp_page_address), .rsp_share_count(rsp_share_count),
      .rsp_released(rsp_released), .rsp_free_pages(rsp_free_pages)
   );

   refcounted_page_allocator_checker #(
      .PAGES(PAGES), .PAGE_BITS(PAGE_BITS), .COUNT_BITS(COUNT_BITS)
   ) u_checker (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_page_address(rsp_page_address), .rsp_share_count(rsp_share_count),
      .rsp_released(rsp_released), .rsp_free_pages(rsp_free_pages),
      .mismatches(mismatches), .replies_owed(replies_owed)
   );

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL refcounted_page_allocator_unit");
         $finish;
      end
   end

   // reply-side back-pressure
   initial begin
      int run;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            run = $urandom_range(1, 11);
         end else begin
            rsp_ready <= 1'b1;
            run = $urandom_range(1, 24);
         end
         repeat (run - 1) @(posedge clock);
      end
   end

   task automatic issue_request(rcpa_pkg::op_type op, logic [31:0] addr);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (replies_owed != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_window(logic [31:0] first, logic [31:0] limit);
      settle();
      csr_we <= 1'b1;
      csr_index <= rcpa_pkg::CSR_FIRST_ADDR;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= rcpa_pkg::CSR_LIMIT_ADDR;
      csr_wdata <= limit;
      @(posedge clock);
      csr_we <= 1'b0;
      window_limit = limit;
      window_base = (first + PAGE_BYTES - 1) & ~(PAGE_BYTES - 1);
   endtask

   // mostly requests on a small set of valid pages, the rest malformed
   task automatic run_mixed_ops(int count, int span);
      int               pick;
      rcpa_pkg::op_type op;
      logic [31:0]      addr;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         addr = window_base + PAGE_BYTES * $urandom_range(0, span - 1);
         if (pick < 25) begin
            op = rcpa_pkg::OP_ALLOC;
            addr = $urandom();
         end else if (pick < 50) begin
            op = rcpa_pkg::OP_FREE;
         end else if (pick < 70) begin
            op = rcpa_pkg::OP_SHARE;
         end else if (pick < 85) begin
            op = rcpa_pkg::OP_DONATE;
         end else begin
            op = rcpa_pkg::op_type'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
               0: addr = $urandom();
               1: addr = addr | $urandom_range(1, PAGE_BYTES - 1);
               2: addr = window_limit - PAGE_BYTES * $urandom_range(0, 1);
               default: addr = window_base - PAGE_BYTES;
            endcase
         end
         issue_request(op, addr);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = rcpa_pkg::CSR_FIRST_ADDR;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_op = rcpa_pkg::OP_ALLOC;
      req_address = '0;
      window_base = rcpa_pkg::FIRST_ADDR_RESET;
      window_limit = rcpa_pkg::LIMIT_ADDR_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty pool, unowned free, share and release, donate, bad addresses
      issue_request(rcpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);
      issue_request(rcpa_pkg::OP_FREE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_SHARE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_SHARE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_FREE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_FREE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_FREE, 32'h8000_0000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h87FF_F000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h8000_1000);
      issue_request(rcpa_pkg::OP_ALLOC, 32'h0000_0000);
      issue_request(rcpa_pkg::OP_SHARE, 32'h8000_1000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h8000_1000);
      issue_request(rcpa_pkg::OP_FREE, 32'h8000_0001);
      issue_request(rcpa_pkg::OP_SHARE, 32'h7FFF_F000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h8800_0000);
      issue_request(rcpa_pkg::OP_FREE, 32'hFFFF_F000);
      issue_request(rcpa_pkg::OP_SHARE, 32'h0000_0000);
      repeat (4) issue_request(rcpa_pkg::OP_ALLOC, $urandom());

      run_mixed_ops(200, 24);

      // drive one page into saturation, then hand it back
      repeat (258) issue_request(rcpa_pkg::OP_SHARE, window_base + 5 * PAGE_BYTES);
      issue_request(rcpa_pkg::OP_DONATE, window_base + 5 * PAGE_BYTES);
      issue_request(rcpa_pkg::OP_FREE, window_base + 5 * PAGE_BYTES);

      // widest window: the table ends before the limit
      set_window(32'h0000_0000, 32'hFFFF_FFFF);
      issue_request(rcpa_pkg::OP_SHARE, 32'h0800_0000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h07FF_F000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h0000_0000);
      issue_request(rcpa_pkg::OP_SHARE, 32'hFFFF_F000);
      repeat (2) issue_request(rcpa_pkg::OP_ALLOC, 32'h0);
      run_mixed_ops(80, 24);

      // base rounds past 32 bits: no address is valid
      set_window(32'hFFFF_F001, 32'hFFFF_FFFF);
      issue_request(rcpa_pkg::OP_DONATE, 32'hFFFF_F000);
      run_mixed_ops(20, 8);

      // unaligned base
      set_window(32'h1234_5678, 32'h1235_5000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h1234_5000);
      run_mixed_ops(60, 20);

      // a single page at the top of the address space
      set_window(32'hFFFF_F000, 32'hFFFF_FFFF);
      issue_request(rcpa_pkg::OP_DONATE, 32'hFFFF_F000);
      issue_request(rcpa_pkg::OP_ALLOC, 32'h0);
      issue_request(rcpa_pkg::OP_SHARE, 32'hFFFF_F000);
      issue_request(rcpa_pkg::OP_FREE, 32'hFFFF_F000);
      issue_request(rcpa_pkg::OP_FREE, 32'hFFFF_F000);
      issue_request(rcpa_pkg::OP_FREE, 32'hFFFF_F000);

      // limit below base
      set_window(32'h0000_0FFF, 32'h0000_0000);
      issue_request(rcpa_pkg::OP_DONATE, 32'h0000_1000);
      run_mixed_ops(10, 4);

      // donate a run of pages, no back-pressure from here on
      stalls_on <= 1'b0;
      set_window(32'h4000_0000, 32'h4800_0000);
      for (int i = 0; i < 40; i++)
         issue_request(rcpa_pkg::OP_DONATE, window_base + PAGE_BYTES * i);
      issue_request(rcpa_pkg::OP_DONATE, 32'h4000_0000);
      issue_request(rcpa_pkg::OP_SHARE, 32'h4000_1000);
      issue_request(rcpa_pkg::OP_FREE, 32'h4000_1000);
      run_mixed_ops(40, 24);

      settle();
      if (mismatches == 0) begin
         $display("PASS refcounted_page_allocator_unit");
      end else begin
         $display("FAIL refcounted_page_allocator_unit");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/rcpa_pkg.sv
design/rcpa_ram.sv
design/rcpa_front.sv
design/rcpa_back.sv
design/refcounted_page_allocator_unit.sv
verif/refcounted_page_allocator_checker.sv
verif/tb_refcounted_page_allocator_unit.sv
